>>> sv/b64d_pkg.sv
// Shared types, constants and the alphabet map for the base64 stream decoder.
// No dependencies; every other file of the block uses this package.
package b64d_pkg;

   // Widths of the length counters and the character/byte paths
   localparam int LenBits   = 16;
   localparam int CharBits  = 8;
   localparam int ByteBits  = 8;

   // Result queue sizing: one decoded group can push up to three beats
   localparam int MaxBeats  = 3;
   localparam int FifoDepth = 8;
   localparam int FifoAw    = $clog2(FifoDepth);

   localparam logic [CharBits-1:0] PadChar  = 8'h3D;  // '='
   localparam logic [CharBits-1:0] EndChar  = 8'h00;  // end of text
   localparam logic [LenBits-1:0]  CapReset = '1;
   localparam logic [LenBits-1:0]  MinSpace = LenBits'(4);

   // Symbol map output: bit 6 set means not in the alphabet
   localparam int SymBits = 7;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_CAPACITY = 2'd1,
      STATUS_ILLEGAL  = 2'd2
   } status_type;

   typedef enum logic {
      KIND_DATA   = 1'b0,
      KIND_REPORT = 1'b1
   } kind_type;

   typedef struct packed {
      logic [ByteBits-1:0] data_byte;
      kind_type            kind;
      status_type          status;
      logic [LenBits-1:0]  decoded_length;
      logic                last;
   } result_type;

   // Beats handed from the decoder to the result queue at once
   typedef struct packed {
      logic [1:0]                    count;
      result_type [MaxBeats-1:0]     beats;
   } push_type;

   // Standard alphabet: A-Z, a-z, 0-9, '+', '/'
   function automatic logic [SymBits-1:0] sym_value(logic [CharBits-1:0] c);
      logic [SymBits-1:0] v;
      if (c >= 8'h41 && c <= 8'h5A) begin
         v = SymBits'(c - 8'h41);
      end else if (c >= 8'h61 && c <= 8'h7A) begin
         v = SymBits'(c - 8'h61 + 8'd26);
      end else if (c >= 8'h30 && c <= 8'h39) begin
         v = SymBits'(c - 8'h30 + 8'd52);
      end else if (c == 8'h2B) begin
         v = SymBits'(62);
      end else if (c == 8'h2F) begin
         v = SymBits'(63);
      end else begin
         v = SymBits'(64);
      end
      return v;
   endfunction

endpackage

>>> sv/b64d_req_if.sv
// Input channel of the base64 decoder: one text character per beat.
// Depends on b64d_pkg for the character width.
interface b64d_req_if;
   logic                          valid;
   logic                          ready;
   logic [b64d_pkg::CharBits-1:0] ch;

   modport source (output valid, output ch, input ready);
   modport sink   (input valid, input ch, output ready);
endinterface

>>> sv/b64d_rsp_if.sv
// Result channel of the base64 decoder: a data byte or the final report per beat.
// Depends on b64d_pkg for field widths.
interface b64d_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [b64d_pkg::ByteBits-1:0] data_byte;
   logic                          kind;
   logic [1:0]                    status;
   logic [b64d_pkg::LenBits-1:0]  decoded_length;
   logic                          last;

   modport source (output valid, output data_byte, output kind, output status,
                   output decoded_length, output last, input ready);
   modport sink   (input valid, input data_byte, input kind, input status,
                   input decoded_length, input last, output ready);
endinterface

>>> sv/base64_stream_decoder_core.sv
// Top level of the streaming base64 decoder: decode stage plus result queue.
// Depends on b64d_pkg, b64d_req_if, b64d_rsp_if, b64d_decode, b64d_result_fifo.
//
//   channel   direction  handshake     payload
//   req_bus   in         valid/ready   ch (8)
//   rsp_bus   out        valid/ready   data_byte (8), kind, status (2),
//                                      decoded_length (16), last
//   csr       in         csr_wr_en     csr_wr_data (16) = out_capacity
//
// One character is taken per cycle unless the input register is full and the
// queue holds more than five beats. A character waits in the input register,
// then its beats (none, one, two or three) enter an 8-deep queue; the first
// beat can be taken the cycle after they enter. Reset is synchronous: it empties
// the queue, drops any partial group and reloads out_capacity with 65535.
module base64_stream_decoder_core (
   input  logic                         clock,
   input  logic                         reset,
   b64d_req_if.sink                     req_bus,
   b64d_rsp_if.source                   rsp_bus,
   input  logic                         csr_wr_en,
   input  logic [b64d_pkg::LenBits-1:0] csr_wr_data
);
   import b64d_pkg::*;

   push_type push;
   logic     room;
   logic     stage_valid;

   b64d_decode u_decode (
      .clock       (clock),
      .reset       (reset),
      .req         (req_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .room        (room),
      .stage_valid (stage_valid),
      .push        (push)
   );

   b64d_result_fifo u_fifo (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .room  (room),
      .rsp   (rsp_bus)
   );

`ifndef SYNTHESIS
   // Beats are only produced for a held character while the queue has room
   a_push_needs_room: assert property (@(posedge clock) disable iff (reset)
      (push.count != 2'd0) |-> (stage_valid && room))
      else $error("decoder pushed beats without queue room");

   // Anything pushed shows up on the result channel next cycle
   a_push_visible: assert property (@(posedge clock) disable iff (reset)
      (push.count != 2'd0) |=> rsp_bus.valid)
      else $error("pushed beat not visible on result channel");

   // A final report always closes its character's beats
   a_report_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.kind) |-> rsp_bus.last)
      else $error("final report without last");

   // Data beats carry no status or length
   a_data_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && !rsp_bus.kind) |->
         (rsp_bus.status == 2'd0 && rsp_bus.decoded_length == '0))
      else $error("data beat with nonzero status or length");
`endif

endmodule

>>> sv/b64d_decode.sv
// Input beat register, group buffer and decode state; emits up to three beats.
// Depends on b64d_pkg and b64d_req_if.
module b64d_decode (
   input  logic                         clock,
   input  logic                         reset,
   b64d_req_if.sink                     req,
   input  logic                         csr_wr_en,
   input  logic [b64d_pkg::LenBits-1:0] csr_wr_data,
   input  logic                         room,
   output logic                         stage_valid,
   output b64d_pkg::push_type           push
);
   import b64d_pkg::*;

   logic                stage_valid_ff, stage_valid_in;
   logic [CharBits-1:0] stage_ch_ff, stage_ch_in;
   logic [1:0]          pos_ff, pos_in;
   logic [23:0]         held_ff, held_in;
   logic                stopped_ff, stopped_in;
   status_type          err_ff, err_in;
   logic [LenBits-1:0]  cap_ff, cap_in;
   logic [LenBits-1:0]  space_ff, space_in;
   logic [LenBits-1:0]  count_ff, count_in;

   logic                fire;
   logic [CharBits-1:0] c0, c1, c2, c3;
   logic [SymBits-1:0]  v0, v1, v2, v3;
   logic [ByteBits-1:0] b0, b1, b2;
   logic [1:0]          n;
   logic                fail;
   status_type          fail_code;

   // Input beat register: refills when empty or whenever the held beat moves on
   assign req.ready   = !stage_valid_ff || room;
   assign fire        = stage_valid_ff && room;
   assign stage_valid = stage_valid_ff;

   always_comb begin
      stage_valid_in = stage_valid_ff;
      stage_ch_in    = stage_ch_ff;
      if (req.ready) begin
         stage_valid_in = req.valid;
         stage_ch_in    = req.ch;
      end
   end

   // Group fields and alphabet map
   assign c0 = held_ff[23:16];
   assign c1 = held_ff[15:8];
   assign c2 = held_ff[7:0];
   assign c3 = stage_ch_ff;
   assign v0 = sym_value(c0);
   assign v1 = sym_value(c1);
   assign v2 = sym_value(c2);
   assign v3 = sym_value(c3);
   assign b0 = {v0[5:0], v1[5:4]};
   assign b1 = {v1[3:0], v2[5:2]};
   assign b2 = {v2[1:0], v3[5:0]};

   // Group checks in priority order: space, first/second, double pad, third, single pad, fourth
   always_comb begin
      fail      = 1'b0;
      fail_code = STATUS_OK;
      n         = 2'd3;
      if (space_ff < MinSpace) begin
         fail      = 1'b1;
         fail_code = STATUS_CAPACITY;
      end else if (v0[6] || v1[6]) begin
         fail      = 1'b1;
         fail_code = STATUS_ILLEGAL;
      end else if (c2 == PadChar && c3 == PadChar) begin
         n = 2'd1;
      end else if (v2[6]) begin
         fail      = 1'b1;
         fail_code = STATUS_ILLEGAL;
      end else if (c3 == PadChar) begin
         n = 2'd2;
      end else if (v3[6]) begin
         fail      = 1'b1;
         fail_code = STATUS_ILLEGAL;
      end
   end

   // Next state and beats for the held character
   always_comb begin
      pos_in     = pos_ff;
      held_in    = held_ff;
      stopped_in = stopped_ff;
      err_in     = err_ff;
      cap_in     = cap_ff;
      space_in   = space_ff;
      count_in   = count_ff;
      push       = '0;

      if (fire) begin
         if (c3 == EndChar) begin
            push.count                   = 2'd1;
            push.beats[0].kind           = KIND_REPORT;
            push.beats[0].status         = err_ff;
            push.beats[0].decoded_length = count_ff;
            push.beats[0].last           = 1'b1;
            pos_in     = '0;
            held_in    = '0;
            stopped_in = 1'b0;
            err_in     = STATUS_OK;
            space_in   = cap_ff;
            count_in   = '0;
         end else if (!stopped_ff) begin
            if (pos_ff != 2'd3) begin
               held_in = {held_ff[15:0], c3};
               pos_in  = pos_ff + 2'd1;
            end else begin
               pos_in  = '0;
               held_in = '0;
               if (fail) begin
                  stopped_in = 1'b1;
                  err_in     = fail_code;
               end else begin
                  stopped_in = (n != 2'd3);
                  space_in   = space_ff - LenBits'(n);
                  count_in   = count_ff + LenBits'(n);
                  push.count = n;
                  push.beats[0].data_byte = b0;
                  push.beats[1].data_byte = (n >= 2'd2) ? b1 : '0;
                  push.beats[2].data_byte = (n == 2'd3) ? b2 : '0;
                  push.beats[0].last      = (n == 2'd1);
                  push.beats[1].last      = (n == 2'd2);
                  push.beats[2].last      = (n == 2'd3);
               end
            end
         end
      end

      // Register write reloads the space counter at once
      if (csr_wr_en) begin
         cap_in   = csr_wr_data;
         space_in = csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      stage_ch_ff <= stage_ch_in;
      if (reset) begin
         stage_valid_ff <= 1'b0;
         pos_ff         <= '0;
         held_ff        <= '0;
         stopped_ff     <= 1'b0;
         err_ff         <= STATUS_OK;
         cap_ff         <= CapReset;
         space_ff       <= CapReset;
         count_ff       <= '0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         pos_ff         <= pos_in;
         held_ff        <= held_in;
         stopped_ff     <= stopped_in;
         err_ff         <= err_in;
         cap_ff         <= cap_in;
         space_ff       <= space_in;
         count_ff       <= count_in;
      end
   end

endmodule

>>> sv/b64d_result_fifo.sv
// Result queue: takes up to three beats a cycle, delivers one beat a cycle while rsp.ready is high.
// Depends on b64d_pkg and b64d_rsp_if.
module b64d_result_fifo (
   input  logic               clock,
   input  logic               reset,
   input  b64d_pkg::push_type push,
   output logic               room,
   b64d_rsp_if.source         rsp
);
   import b64d_pkg::*;

   result_type          mem_ff [FifoDepth];
   logic [FifoAw-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [FifoAw-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [FifoAw:0]     fill_ff, fill_in;
   logic                pop;
   result_type          head;

   // Room for a full group's worth of beats
   assign room = (fill_ff <= (FifoAw + 1)'(FifoDepth - MaxBeats));
   assign pop  = rsp.valid && rsp.ready;
   assign head = mem_ff[rd_ptr_ff];

   assign rsp.valid          = (fill_ff != '0);
   assign rsp.data_byte      = head.data_byte;
   assign rsp.kind           = head.kind;
   assign rsp.status         = head.status;
   assign rsp.decoded_length = head.decoded_length;
   assign rsp.last           = head.last;

   always_comb begin
      wr_ptr_in = wr_ptr_ff + FifoAw'(push.count);
      rd_ptr_in = rd_ptr_ff + FifoAw'(pop);
      fill_in   = fill_ff + (FifoAw + 1)'(push.count) - (FifoAw + 1)'(pop);
   end

   // Storage: beat i of a push lands i slots past the write pointer
   always_ff @(posedge clock) begin
      for (int i = 0; i < MaxBeats; i++) begin
         if (2'(i) < push.count) begin
            mem_ff[wr_ptr_ff + FifoAw'(i)] <= push.beats[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

endmodule
